// ===== hdl/tlr_pkg.sv =====
// Package for the thick line rasterizer: codes, defaults and the
// controller/datapath interface structs. No dependencies.
package tlr_pkg;

  localparam int CFG_W          = 13;
  localparam int CFG_IDX_W      = 1;
  localparam int COLOUR_W       = 16;
  localparam int COORD_BITS_DEF = 12;
  localparam int THICK_BITS_DEF = 8;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd320;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd240;

  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_HEIGHT = 1'b1;

  localparam logic KIND_CMD = 1'b0;
  localparam logic KIND_ADV = 1'b1;

  localparam logic [1:0] MODE_MIDDLE = 2'd0;
  localparam logic [1:0] MODE_CW     = 2'd1;
  localparam logic [1:0] MODE_CCW    = 2'd2;

  typedef struct packed {
    logic load;       // latch a new command request
    logic setup;      // derive perpendicular walk parameters
    logic walk;       // one backward perpendicular step
    logic perp_init;  // reinitialize perpendicular error
    logic start;      // begin a sub-line
    logic step;       // one inner Bresenham step
    logic finish;     // forward perpendicular step to the next sub-line
    logic emit;       // load the output register
    logic emit_ovl;   // select the overlap pixel for the output
    logic final_pix;  // mark the emitted pixel as last
  } tlr_cmd_t;

  typedef struct packed {
    logic adj_zero;
    logic out_free;
    logic done;
    logic rem_zero;
    logic need_ovl;
  } tlr_status_t;

endpackage

// ===== hdl/tlr_datapath.sv =====
// Datapath of the thick line rasterizer: configuration registers, walk and
// line state, Bresenham step logic and the output register. Uses tlr_pkg.
module tlr_datapath import tlr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int THICK_BITS = THICK_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic [COORD_BITS-1:0] in_x_first,
  input  logic [COORD_BITS-1:0] in_y_first,
  input  logic [COORD_BITS-1:0] in_x_last,
  input  logic [COORD_BITS-1:0] in_y_last,
  input  logic [THICK_BITS-1:0] in_thickness,
  input  logic [1:0]            in_side_mode,
  input  logic [COLOUR_W-1:0]   in_colour,
  input  tlr_cmd_t              cmd,
  output tlr_status_t           status,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] out_pixel_x,
  output logic [COORD_BITS-1:0] out_pixel_y,
  output logic [COLOUR_W-1:0]   out_pixel_colour,
  output logic                  out_final_pixel
);

  localparam int CB   = COORD_BITS;
  localparam int TB   = THICK_BITS;
  localparam int EW   = ((CB > TB) ? CB : TB) + 2;
  localparam int ERRW = CB + 3;
  localparam int LW   = (CFG_W > CB + 1) ? CFG_W : CB + 1;

  function automatic logic [CB-1:0] size_lim(input logic [CFG_W-1:0] r);
    logic [LW-1:0] rw;
    rw = LW'(r);
    if (r == '0) return '0;
    else if (rw > (LW'(1) << CB)) return '1;
    else return CB'(rw - LW'(1));
  endfunction

  function automatic logic [CB-1:0] clip_u(input logic [CB-1:0] v, input logic [CB-1:0] lim);
    return (v > lim) ? lim : v;
  endfunction

  function automatic logic [CB-1:0] clip_s(input logic signed [EW-1:0] v,
                                           input logic [CB-1:0] lim);
    logic signed [EW-1:0] lw;
    lw = $signed(EW'(lim));
    if (v < 0) return '0;
    else if (v > lw) return lim;
    else return CB'(v);
  endfunction

  function automatic logic signed [ERRW-1:0] dbl(input logic [CB-1:0] d);
    return $signed(ERRW'({d, 1'b0}));
  endfunction

  function automatic logic signed [ERRW-1:0] ext(input logic [CB-1:0] d);
    return $signed(ERRW'(d));
  endfunction

  logic [CFG_W-1:0]           width_r, height_r;
  logic signed [EW-1:0]       ep_r [4];
  logic signed [ERRW-1:0]     perr_r, ierr_r;
  logic [CB-1:0]              pd_r [2];
  logic                       ps_r [2];
  logic [CB-1:0]              id_r [2];
  logic                       is_r [2];
  logic [CB-1:0]              cur_r [2];
  logic [CB-1:0]              end_r [2];
  logic [TB-1:0]              rem_r, adj_r, thick_r;
  logic [1:0]                 mode_r;
  logic                       ovl_flag_r, need_ovl_r;
  logic [COLOUR_W-1:0]        colour_r;
  logic [CB-1:0]              ovl_x_r, ovl_y_r;
  logic                       out_valid_r;
  logic [CB-1:0]              px_r, py_r;
  logic [COLOUR_W-1:0]        pcol_r;
  logic                       fin_r;

  logic [CB-1:0] lim_x, lim_y;
  assign lim_x = size_lim(width_r);
  assign lim_y = size_lim(height_r);

  // ---- setup of the perpendicular walk
  logic signed [EW-1:0] ax, ay;
  logic                 sx, sy, swap, x_major;
  logic [CB-1:0]        dax, day;
  logic [TB-1:0]        adj0, adj_inv, adj_s;
  logic                 psx_s, psy_s, thin;
  logic signed [ERRW-1:0] perr_s;

  always_comb begin
    ax = ep_r[3] - ep_r[1];
    ay = ep_r[2] - ep_r[0];
    sx = ax < 0;
    sy = ay < 0;
    dax = CB'(sx ? -ax : ax);
    day = CB'(sy ? -ay : ay);
    swap = ~(sx ^ sy);
    thin = thick_r <= TB'(1);
    if (mode_r == MODE_CCW) adj0 = thick_r - TB'(1);
    else if (mode_r == MODE_CW) adj0 = '0;
    else adj0 = thick_r >> 1;
    adj_inv = thick_r - TB'(1) - adj0;
    x_major = dax >= day;
    adj_s = adj0;
    psx_s = sx;
    psy_s = sy;
    if (x_major == swap) begin
      adj_s = adj_inv;
      psy_s = ~sy;
    end else begin
      psx_s = ~sx;
    end
    perr_s = x_major ? (dbl(day) - ext(dax)) : (dbl(dax) - ext(day));
  end

  // ---- one perpendicular step; direction backward for the initial walk
  logic                   p0, sgp, sgq, pminor;
  logic [CB-1:0]          dp, dq;
  logic signed [EW-1:0]   stp_p, stp_q, addx, addy;
  logic signed [ERRW-1:0] perr_mv, perr_init;

  always_comb begin
    p0 = pd_r[0] >= pd_r[1];
    dp = p0 ? pd_r[0] : pd_r[1];
    dq = p0 ? pd_r[1] : pd_r[0];
    sgp = (p0 ? ps_r[0] : ps_r[1]) ^ cmd.walk;
    sgq = (p0 ? ps_r[1] : ps_r[0]) ^ cmd.walk;
    stp_p = sgp ? -EW'(1) : EW'(1);
    stp_q = sgq ? -EW'(1) : EW'(1);
    pminor = perr_r >= 0;
    addx = p0 ? stp_p : (pminor ? stp_q : '0);
    addy = p0 ? (pminor ? stp_q : '0) : stp_p;
    perr_mv = perr_r - (pminor ? dbl(dp) : '0) + dbl(dq);
    perr_init = dbl(dq) - ext(dp);
  end

  // ---- sub-line start
  logic [CB-1:0]         bx0, by0, bx1, by1, bdx, bdy;
  logic signed [CB:0]    dxs, dys;
  logic signed [ERRW-1:0] ierr_s;

  always_comb begin
    bx0 = clip_s(ep_r[0], lim_x);
    by0 = clip_s(ep_r[1], lim_y);
    bx1 = clip_s(ep_r[2], lim_x);
    by1 = clip_s(ep_r[3], lim_y);
    dxs = $signed({1'b0, bx1}) - $signed({1'b0, bx0});
    dys = $signed({1'b0, by1}) - $signed({1'b0, by0});
    bdx = CB'(dxs < 0 ? -dxs : dxs);
    bdy = CB'(dys < 0 ? -dys : dys);
    ierr_s = (bdx > bdy) ? (dbl(bdy) - ext(bdx)) : (dbl(bdx) - ext(bdy));
  end

  // ---- inner Bresenham step
  logic                   a0, iminor;
  logic [CB-1:0]          maj_x, maj_y, nx, ny;
  logic signed [ERRW-1:0] ierr_nx;

  always_comb begin
    a0 = id_r[0] > id_r[1];
    iminor = ierr_r >= 0;
    maj_x = a0 ? (is_r[0] ? cur_r[0] - CB'(1) : cur_r[0] + CB'(1)) : cur_r[0];
    maj_y = a0 ? cur_r[1] : (is_r[1] ? cur_r[1] - CB'(1) : cur_r[1] + CB'(1));
    nx = maj_x;
    ny = maj_y;
    if (iminor) begin
      if (a0) ny = is_r[1] ? maj_y - CB'(1) : maj_y + CB'(1);
      else    nx = is_r[0] ? maj_x - CB'(1) : maj_x + CB'(1);
    end
    ierr_nx = ierr_r - (iminor ? dbl(a0 ? id_r[0] : id_r[1]) : '0)
              + dbl(a0 ? id_r[1] : id_r[0]);
  end

  always_comb begin
    status.adj_zero = adj_r == '0;
    status.out_free = ~out_valid_r | ~out_stall;
    status.done     = a0 ? (cur_r[0] == end_r[0]) : (cur_r[1] == end_r[1]);
    status.rem_zero = rem_r == '0;
    status.need_ovl = need_ovl_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= WIDTH_RESET;
      height_r    <= HEIGHT_RESET;
      out_valid_r <= 1'b0;
      rem_r       <= '0;
      adj_r       <= '0;
      ovl_flag_r  <= 1'b0;
      need_ovl_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_DISPLAY_WIDTH) width_r <= cfg_data;
        else                                height_r <= cfg_data;
      end
      if (cmd.load) begin
        ep_r[0]    <= $signed(EW'(clip_u(in_x_first, lim_x)));
        ep_r[1]    <= $signed(EW'(clip_u(in_y_first, lim_y)));
        ep_r[2]    <= $signed(EW'(clip_u(in_x_last, lim_x)));
        ep_r[3]    <= $signed(EW'(clip_u(in_y_last, lim_y)));
        thick_r    <= in_thickness;
        mode_r     <= in_side_mode;
        colour_r   <= in_colour;
        ovl_flag_r <= 1'b0;
      end
      if (cmd.setup) begin
        if (thin) begin
          pd_r[0] <= '0; pd_r[1] <= '0;
          ps_r[0] <= 1'b0; ps_r[1] <= 1'b0;
          perr_r  <= '0;
          rem_r   <= '0;
          adj_r   <= '0;
        end else begin
          pd_r[0] <= dax; pd_r[1] <= day;
          ps_r[0] <= psx_s; ps_r[1] <= psy_s;
          perr_r  <= perr_s;
          rem_r   <= thick_r - TB'(1);
          adj_r   <= adj_s;
        end
      end
      if (cmd.walk || cmd.finish) begin
        ep_r[0] <= ep_r[0] + addx;
        ep_r[2] <= ep_r[2] + addx;
        ep_r[1] <= ep_r[1] + addy;
        ep_r[3] <= ep_r[3] + addy;
        perr_r  <= perr_mv;
      end
      if (cmd.walk) adj_r <= adj_r - TB'(1);
      if (cmd.finish) begin
        rem_r      <= rem_r - TB'(1);
        ovl_flag_r <= pminor;
      end
      if (cmd.perp_init) perr_r <= perr_init;
      if (cmd.start) begin
        cur_r[0] <= bx0; cur_r[1] <= by0;
        end_r[0] <= bx1; end_r[1] <= by1;
        id_r[0]  <= bdx; id_r[1] <= bdy;
        is_r[0]  <= dxs < 0; is_r[1] <= dys < 0;
        ierr_r   <= ierr_s;
      end
      if (cmd.step) begin
        ovl_x_r    <= maj_x;
        ovl_y_r    <= maj_y;
        need_ovl_r <= iminor & ovl_flag_r;
        cur_r[0]   <= nx;
        cur_r[1]   <= ny;
        ierr_r     <= ierr_nx;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        px_r        <= cmd.emit_ovl ? ovl_x_r : cur_r[0];
        py_r        <= cmd.emit_ovl ? ovl_y_r : cur_r[1];
        pcol_r      <= colour_r;
        fin_r       <= cmd.final_pix;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_x      = px_r;
  assign out_pixel_y      = py_r;
  assign out_pixel_colour = pcol_r;
  assign out_final_pixel  = fin_r;

endmodule

// ===== hdl/tlr_ctrl.sv =====
// Controller of the thick line rasterizer: sequences command setup, the
// perpendicular walk, sub-line starts and pixel emission. Uses tlr_pkg.
module tlr_ctrl import tlr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_kind,
  output logic        in_stall,
  input  tlr_status_t status,
  output tlr_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_WALK, S_BEGIN, S_STEP, S_OVL, S_MAIN, S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    PH_IDLE, PH_START, PH_STEP
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    phase_nxt = phase_r;
    in_stall  = state_r != S_IDLE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_CMD) begin
            cmd.load  = 1'b1;
            state_nxt = S_SETUP;
          end else if (phase_r == PH_START) begin
            state_nxt = S_MAIN;
          end else if (phase_r == PH_STEP) begin
            state_nxt = S_STEP;
          end
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (status.adj_zero) begin
          cmd.perp_init = 1'b1;
          state_nxt     = S_BEGIN;
        end else begin
          cmd.walk = 1'b1;
        end
      end
      S_BEGIN: begin
        cmd.start = 1'b1;
        phase_nxt = PH_START;
        state_nxt = S_IDLE;
      end
      S_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = S_OVL;
      end
      S_OVL: begin
        if (!status.need_ovl) begin
          state_nxt = S_MAIN;
        end else if (status.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_ovl = 1'b1;
          state_nxt    = S_MAIN;
        end
      end
      S_MAIN: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.final_pix = status.done & status.rem_zero;
          if (!status.done) begin
            phase_nxt = PH_STEP;
            state_nxt = S_IDLE;
          end else if (status.rem_zero) begin
            phase_nxt = PH_IDLE;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = S_BEGIN;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_IDLE;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

// ===== hdl/thick_line_rasterizer_unit.sv =====
// Thick line rasterizer top level: controller plus datapath.
// Depends on tlr_pkg, tlr_ctrl and tlr_datapath.
// A command request: load, setup, S backward perpendicular steps that
// center the shape (up to thickness-1), error seed, sub-line start.
// An advance request emits a pixel in the start phase; in the stepping
// phase it steps and emits, plus a sub-line start when one closes.
// One request at a time; pixels leave through a single output register.
// Reset (rst_n low, synchronous) idles the block and restores 320 x 240.
module thick_line_rasterizer_unit import tlr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int THICK_BITS = THICK_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_kind,
  input  logic [COORD_BITS-1:0] in_x_first,
  input  logic [COORD_BITS-1:0] in_y_first,
  input  logic [COORD_BITS-1:0] in_x_last,
  input  logic [COORD_BITS-1:0] in_y_last,
  input  logic [THICK_BITS-1:0] in_thickness,
  input  logic [1:0]            in_side_mode,
  input  logic [COLOUR_W-1:0]   in_colour,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] out_pixel_x,
  output logic [COORD_BITS-1:0] out_pixel_y,
  output logic [COLOUR_W-1:0]   out_pixel_colour,
  output logic                  out_final_pixel
);

  tlr_cmd_t    cmd;
  tlr_status_t status;

  // Sequence each request: setup, walk, sub-line start, step and emit.
  tlr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold the shape state and the output register; advance on commands.
  tlr_datapath #(
    .COORD_BITS (COORD_BITS),
    .THICK_BITS (THICK_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_x_first       (in_x_first),
    .in_y_first       (in_y_first),
    .in_x_last        (in_x_last),
    .in_y_last        (in_y_last),
    .in_thickness     (in_thickness),
    .in_side_mode     (in_side_mode),
    .in_colour        (in_colour),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_pixel_colour (out_pixel_colour),
    .out_final_pixel  (out_final_pixel)
  );

endmodule

// ===== tb/thick_line_rasterizer_unit_tb.sv =====
// Self-checking testbench for thick_line_rasterizer_unit: predicts every pixel
// of each thick line from command and advance requests and checks the output.
// Depends on tlr_pkg and the thick_line_rasterizer_unit RTL.
module thick_line_rasterizer_unit_tb;
  import tlr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [15:0] colour;
    logic        last;
  } pixel_t;

  // Pixel predictor and queue of pixels still owed by the block.
  class pixel_scoreboard;
    int unsigned width_reg, height_reg;
    bit          active;
    int          ends[4];
    int          perr;
    int          pd[2];
    bit          ps[2];
    int unsigned remaining;
    int          cur[2];
    int          ierr;
    int          id[2];
    bit          is[2];
    bit          ovl;
    logic [15:0] colour_hold;
    int unsigned phase;
    int          end_xy[2];
    pixel_t      owed[$];
    int          errors;
    int          checked;

    function void reset_state();
      width_reg = 320; height_reg = 240;
      active = 0; perr = 0; ierr = 0; remaining = 0; ovl = 0;
      colour_hold = '0; phase = 0;
      foreach (ends[i]) ends[i] = 0;
      for (int i = 0; i < 2; i++) begin
        pd[i] = 0; ps[i] = 0; cur[i] = 0; id[i] = 0; is[i] = 0; end_xy[i] = 0;
      end
      owed.delete();
      errors = 0; checked = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
      if (idx == CFG_DISPLAY_WIDTH) width_reg = v;
      else height_reg = v;
    endfunction

    function int size_limit(int unsigned r);
      if (r == 0) return 0;
      if (r > 4096) r = 4096;
      return r - 1;
    endfunction

    function int clip(int v, int lim);
      if (v < 0) return 0;
      if (v > lim) return lim;
      return v;
    endfunction

    function int dir(bit neg);
      return neg ? -1 : 1;
    endfunction

    function void start_line();
      int lx, ly, x0, y0, x1, y1, dx, dy;
      lx = size_limit(width_reg); ly = size_limit(height_reg);
      x0 = clip(ends[0], lx); y0 = clip(ends[1], ly);
      x1 = clip(ends[2], lx); y1 = clip(ends[3], ly);
      dx = x1 - x0; dy = y1 - y0;
      is[0] = dx < 0; is[1] = dy < 0;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      id[0] = dx; id[1] = dy;
      ierr = (dx > dy) ? 2 * dy - dx : 2 * dx - dy;
      cur[0] = x0; cur[1] = y0; end_xy[0] = x1; end_xy[1] = y1;
      phase = 1; active = 1;
    endfunction

    function bit perp_step(int d);
      int p, q, sp, sq;
      bit minor;
      p = (pd[0] >= pd[1]) ? 0 : 1; q = 1 - p; minor = 0;
      sp = dir(ps[p]) * d; sq = dir(ps[q]) * d;
      ends[p] += sp; ends[p+2] += sp;
      if (perr >= 0) begin
        ends[q] += sq; ends[q+2] += sq;
        perr -= 2 * pd[p];
        minor = 1;
      end
      perr += 2 * pd[q];
      return minor;
    endfunction

    function void perp_seed();
      int p;
      p = (pd[0] >= pd[1]) ? 0 : 1;
      perr = 2 * pd[1-p] - pd[p];
    endfunction

    function void push_pixel();
      pixel_t px;
      px.x = cur[0][11:0]; px.y = cur[1][11:0];
      px.colour = colour_hold; px.last = 0;
      owed.push_back(px);
    endfunction

    function void close_line(int emitted);
      if (remaining == 0) begin
        if (emitted > 0) owed[$].last = 1;
        phase = 0; active = 0;
      end else begin
        remaining--;
        ovl = perp_step(1);
        start_line();
      end
    endfunction

    // Note an accepted request and append the pixels it produces.
    function void note_request(logic kind, logic [11:0] xf, logic [11:0] yf,
                               logic [11:0] xl, logic [11:0] yl, logic [7:0] th,
                               logic [1:0] mode, logic [15:0] col);
      int lx, ly, xs, ys, xe, ye, thick, ax, ay, adj, a, b, n;
      bit swap;
      n = 0;
      if (kind == KIND_CMD) begin
        lx = size_limit(width_reg); ly = size_limit(height_reg);
        xs = clip(xf, lx); ys = clip(yf, ly); xe = clip(xl, lx); ye = clip(yl, ly);
        thick = th; colour_hold = col;
        ends[0] = xs; ends[1] = ys; ends[2] = xe; ends[3] = ye;
        ovl = 0;
        if (thick <= 1) begin
          pd[0] = 0; pd[1] = 0; ps[0] = 0; ps[1] = 0; perr = 0; remaining = 0;
          start_line();
          return;
        end
        ax = ye - ys; ay = xe - xs; swap = 1;
        ps[0] = ax < 0; ps[1] = ay < 0;
        if (ax < 0) begin ax = -ax; swap = !swap; end
        if (ay < 0) begin ay = -ay; swap = !swap; end
        pd[0] = ax; pd[1] = ay;
        if (mode == MODE_CCW) adj = thick - 1;
        else if (mode == MODE_CW) adj = 0;
        else adj = thick / 2;
        if (ax >= ay) begin
          if (swap) begin adj = (thick - 1) - adj; ps[1] = !ps[1]; end
          else ps[0] = !ps[0];
        end else begin
          if (swap) ps[0] = !ps[0];
          else begin adj = (thick - 1) - adj; ps[1] = !ps[1]; end
        end
        perp_seed();
        for (; adj > 0; adj--) void'(perp_step(-1));
        perp_seed();
        remaining = thick - 1;
        start_line();
        return;
      end
      a = (id[0] > id[1]) ? 0 : 1; b = 1 - a;
      if (phase == 1) begin
        push_pixel(); n++;
        if (cur[a] == end_xy[a]) close_line(n);
        else phase = 2;
      end else if (phase == 2) begin
        cur[a] += dir(is[a]);
        if (ierr >= 0) begin
          if (ovl) begin push_pixel(); n++; end
          cur[b] += dir(is[b]);
          ierr -= 2 * id[a];
        end
        ierr += 2 * id[b];
        push_pixel(); n++;
        if (cur[a] == end_xy[a]) close_line(n);
      end
    endfunction

    // Compare one output pixel with the oldest owed pixel.
    function void check_pixel(pixel_t got);
      pixel_t want;
      checked++;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected pixel x=%0d y=%0d", got.x, got.y);
        return;
      end
      want = owed.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: pixel mismatch exp x=%0d y=%0d c=%h f=%b got x=%0d y=%0d c=%h f=%b",
                   want.x, want.y, want.colour, want.last,
                   got.x, got.y, got.colour, got.last);
      end
    endfunction
  endclass

  logic                 clk = 0;
  logic                 rst_n = 0;
  logic                 cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 0;
  logic                 in_stall;
  logic                 in_kind = KIND_ADV;
  logic [11:0]          in_x_first = '0, in_y_first = '0, in_x_last = '0, in_y_last = '0;
  logic [7:0]           in_thickness = '0;
  logic [1:0]           in_side_mode = MODE_MIDDLE;
  logic [15:0]          in_colour = '0;
  logic                 out_valid;
  logic                 out_stall = 0;
  logic [11:0]          out_pixel_x, out_pixel_y;
  logic [15:0]          out_pixel_colour;
  logic                 out_final_pixel;

  thick_line_rasterizer_unit uut (.*);

  pixel_scoreboard sb = new();
  int unsigned     cycle_count = 0;
  int unsigned     requests_sent = 0;
  int unsigned     commands_sent = 0;
  bit              hold_off = 0;
  bit              random_stall = 0;
  localparam int unsigned CYCLE_LIMIT = 1500000;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Abort the run if the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Check accepted pixels at each edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_pixel({out_pixel_x, out_pixel_y, out_pixel_colour, out_final_pixel});
    end
  end

  function int unsigned gap_len();
    // Mostly no gap, sometimes a short one, now and then a long one.
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Receiver stall: held during a hold-off, else random when enabled, else off.
  always @(posedge clk) begin
    if (hold_off) out_stall <= 1;
    else if (random_stall) out_stall <= (gap_len() != 0);
    else out_stall <= 0;
  end

  // Offer one request, wait until the block takes it and note it; then add a random gap.
  task automatic send_request(logic kind, logic [11:0] xf, logic [11:0] yf,
                              logic [11:0] xl, logic [11:0] yl, logic [7:0] th,
                              logic [1:0] mode, logic [15:0] col, bit gaps);
    int unsigned g;
    in_valid <= 1; in_kind <= kind;
    in_x_first <= xf; in_y_first <= yf; in_x_last <= xl; in_y_last <= yl;
    in_thickness <= th; in_side_mode <= mode; in_colour <= col;
    do @(posedge clk); while (in_stall);
    sb.note_request(kind, xf, yf, xl, yl, th, mode, col);
    requests_sent++;
    if (kind == KIND_CMD) commands_sent++;
    g = gaps ? gap_len() : 0;
    if (g != 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic advance(bit gaps);
    send_request(KIND_ADV, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                 8'($urandom), 2'($urandom_range(0, 3)), 16'($urandom), gaps);
  endtask

  // Advance until the current shape has produced its last pixel.
  task automatic run_shape(bit gaps);
    while (sb.active) advance(gaps);
  endtask

  // Drain owed pixels, then let the block settle before touching registers.
  task automatic drain();
    in_valid <= 0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
    cfg_we <= 0;
  endtask

  task automatic command(logic [11:0] xf, logic [11:0] yf, logic [11:0] xl,
                         logic [11:0] yl, logic [7:0] th, logic [1:0] mode,
                         logic [15:0] col, bit gaps);
    send_request(KIND_CMD, xf, yf, xl, yl, th, mode, col, gaps);
  endtask

  // Random command, mostly short lines on a small display area.
  task automatic random_command(bit gaps);
    logic [11:0] xf, yf, xl, yl;
    logic [7:0]  th;
    xf = 12'($urandom_range(0, 5)); yf = 12'($urandom_range(0, 5));
    xl = 12'($urandom_range(0, 5)); yl = 12'($urandom_range(0, 5));
    if ($urandom_range(0, 9) == 0) begin
      xf = 12'($urandom); yl = 12'($urandom);
    end
    th = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(4, 8)) : 8'($urandom_range(0, 3));
    command(xf, yf, xl, yl, th, 2'($urandom_range(0, 3)), 16'($urandom), gaps);
  endtask

  initial begin
    sb.reset_state();
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: idle advance, thin/thick lines, every side mode, extremes.
    advance(0);
    command(0, 0, 0, 0, 0, MODE_MIDDLE, 16'h0000, 0); run_shape(0);
    command(5, 5, 8, 6, 1, MODE_MIDDLE, 16'hFFFF, 0); run_shape(0);
    command(10, 10, 13, 11, 4, MODE_MIDDLE, 16'h1234, 0); run_shape(0);
    command(12, 10, 10, 13, 2, MODE_CW, 16'hA5A5, 0); run_shape(0);
    command(20, 20, 19, 17, 2, MODE_CCW, 16'h5A5A, 0); run_shape(0);
    command(8, 20, 11, 20, 2, 2'd3, 16'h00FF, 0); run_shape(0);
    command(4095, 4095, 4090, 4093, 2, MODE_CCW, 16'hFF00, 0); run_shape(0);
    // Drop a running shape with a new command.
    command(1, 1, 50, 30, 6, MODE_CW, 16'h0F0F, 0);
    advance(0); advance(0);
    command(4095, 0, 312, 6, 2, MODE_MIDDLE, 16'hF0F0, 0); run_shape(0);
    drain();

    // Tiny display and a huge one.
    write_reg(CFG_DISPLAY_WIDTH, 13'd0);
    write_reg(CFG_DISPLAY_HEIGHT, 13'd1);
    command(3, 3, 9, 9, 3, MODE_MIDDLE, 16'h0001, 0); run_shape(0);
    drain();
    write_reg(CFG_DISPLAY_WIDTH, 13'h1FFF);
    write_reg(CFG_DISPLAY_HEIGHT, 13'd4096);
    command(4095, 4095, 4091, 4090, 3, MODE_CCW, 16'h8001, 0); run_shape(0);
    drain();

    // Long receiver hold-off while the sender keeps offering.
    write_reg(CFG_DISPLAY_WIDTH, 13'd64);
    write_reg(CFG_DISPLAY_HEIGHT, 13'd48);
    hold_off = 1;
    fork
      begin
        command(2, 2, 8, 5, 2, MODE_MIDDLE, 16'hBEEF, 0);
        run_shape(0);
      end
      begin
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
    join
    drain();

    // Random phases over several display sizes, with random stalls.
    random_stall = 1;
    for (int phase_i = 0; phase_i < 2; phase_i++) begin
      write_reg(CFG_DISPLAY_WIDTH, 13'($urandom_range(1, 16)));
      write_reg(CFG_DISPLAY_HEIGHT, 13'($urandom_range(1, 16)));
      repeat (3) begin
        random_command(1);
        if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 4)) advance(1);
        else run_shape(1);
      end
      run_shape(1);
      drain();
    end
    write_reg(CFG_DISPLAY_WIDTH, 13'd4096);
    write_reg(CFG_DISPLAY_HEIGHT, 13'd1);
    repeat (2) begin random_command(1); run_shape(1); end
    drain();
    random_stall = 0;
    repeat (40) @(posedge clk);

    $display("Covered %0d requests (%0d commands), %0d pixels checked.",
             requests_sent, commands_sent, sb.checked);
    $display("Display sizes from 1x1 to 4096 wide; all side modes; drops and stalls.");
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
